### src/nrsh_pkg.sv
// Shared types, widths and state codes for the nearest ray/segment hit block.
// No dependencies; every other file in src imports this package.
package nrsh_pkg;

    // Coordinate and result formats
    localparam int COORD_W         = 16;            // signed Q4.12
    localparam int PARAM_FRAC_BITS = 16;            // fraction bits of the ray parameter
    localparam int T_W             = 32;            // ray parameter width, saturating

    // Derived datapath widths
    localparam int DIFF_W   = COORD_W + 1;          // coordinate differences
    localparam int MUL_W    = COORD_W + 2;          // shared multiplier operand
    localparam int PROD_W   = 2 * MUL_W;            // shared multiplier product
    localparam int CROSS_W  = 2 * COORD_W + 3;      // cross products, signed
    localparam int NUM_W    = CROSS_W + T_W;        // divider dividend
    localparam int CNT_W    = $clog2(T_W + 1);      // divider step counter
    localparam int T_SAT_SH = T_W - PARAM_FRAC_BITS;
    localparam int MCNT_W   = 3;                    // multiplier issue counter

    // Multiplier issue counts
    localparam logic [MCNT_W-1:0] XPROD_LAST = MCNT_W'(6);
    localparam logic [MCNT_W-1:0] HPROD_LAST = MCNT_W'(2);

    // One input item: ray, wall segment and group end flag
    typedef struct packed {
        logic signed [COORD_W-1:0] ray_origin_x;
        logic signed [COORD_W-1:0] ray_origin_y;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic                      last_segment;
    } seg_item_t;

    // One result item: nearest hit of a group
    typedef struct packed {
        logic                      hit_valid;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic [T_W-1:0]            hit_param;
    } hit_item_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_CHECK,
        ST_DSTART,
        ST_DWAIT,
        ST_TCMP,
        ST_HMUL,
        ST_HFIX,
        ST_FINISH
    } nrsh_state_t;

endpackage

### src/nrsh_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nrsh_pkg for operand and product widths.
module nrsh_mul
    import nrsh_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;

    // Register the product before anything uses it
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### src/nrsh_div.sv
// Iterative restoring divider: one quotient bit per cycle, T_W bits a division.
// Depends on nrsh_pkg; the high dividend part must be below the divisor.
module nrsh_div
    import nrsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CROSS_W-1:0] num_hi,
    input  logic [T_W-1:0]     num_lo,
    input  logic [CROSS_W-1:0] divisor,
    output div_status_t        status,
    output logic [T_W-1:0]     quot,
    output logic [CROSS_W-1:0] rem
);

    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [CROSS_W-1:0] rem_reg;
    logic [CROSS_W-1:0] rem_next;
    logic [T_W-1:0]     q_reg;
    logic [T_W-1:0]     q_next;
    logic [CROSS_W-1:0] div_reg;
    logic [CROSS_W:0]   trial;
    logic [CROSS_W:0]   trial_diff;

    // Shift in the next dividend bit and try a subtraction
    always_comb
    begin
        trial      = {rem_reg, q_reg[T_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial_diff[CROSS_W-1:0];
            q_next   = {q_reg[T_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CROSS_W-1:0];
            q_next   = {q_reg[T_W-2:0], 1'b0};
        end
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(T_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Remainder, quotient and divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_hi;
            q_reg   <= num_lo;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quot        = q_reg;
    assign rem         = rem_reg;

endmodule

### src/nearest_ray_segment_hit.sv
// Top level of the nearest ray/segment hit finder: sequencer and datapath.
// Depends on nrsh_pkg, nrsh_mul and nrsh_div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  ray     | in        | ray_valid/ray_stall| seg_item_t (ray, segment)
//  res     | out       | res_valid/res_stall| hit_item_t (nearest hit)
//
// An item that misses passes the cross product, normalise and check states before
// the next item can be taken (a parallel one skips the check); one that hits adds
// the ray parameter division unless its parameter saturates, and one that becomes
// the new nearest hit adds the two hit point divisions. All of them run on the
// shared 32-step restoring divider.
// Reset clears the kept hit and returns the sequencer to idle at once.
// ray_stall is high from acceptance until the item is finished; the item
// with last_segment set waits at the end while the previous result is
// still stalled in the output register.
module nearest_ray_segment_hit
    import nrsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ray_valid,
    output logic      ray_stall,
    input  seg_item_t ray,
    output logic      res_valid,
    input  logic      res_stall,
    output hit_item_t res
);

    nrsh_state_t state_reg;
    nrsh_state_t state_next;

    // Item registers
    logic signed [DIFF_W-1:0]  ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [COORD_W-1:0] dx_reg, dy_reg, ax_reg, ay_reg;
    logic                      last_reg;

    // Working registers
    logic signed [CROSS_W-1:0] den_reg, tn_reg, un_reg;
    logic [NUM_W-1:0]          acc_reg;
    logic [T_W-1:0]            tq_reg;
    logic signed [COORD_W-1:0] cand_x_reg;
    logic [MCNT_W-1:0]         mcnt_reg;
    logic                      axis_reg;
    logic                      h_phase_reg;

    // Kept hit
    logic                      best_found_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg;
    logic [T_W-1:0]            best_t_reg;

    // Output register
    logic                      res_valid_reg;
    hit_item_t                 res_reg;

    // Shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      div_start;
    div_status_t               div_st;
    logic [T_W-1:0]            div_quot;
    logic [CROSS_W-1:0]        div_rem;

    // Decisions
    logic                      accept;
    logic                      hit_ok;
    logic                      t_sat;
    logic                      upd;
    logic                      out_free;
    logic                      emit;

    // Hit point arithmetic
    logic signed [DIFF_W-1:0]  e_sel;
    logic                      e_neg;
    logic [DIFF_W-1:0]         e_abs;
    logic signed [COORD_W-1:0] a_sel;
    logic [DIFF_W:0]           q_part, q_up, h_off, h_sum;
    logic signed [COORD_W-1:0] h_val;

    nrsh_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    nrsh_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_hi  (acc_reg[NUM_W-1:T_W]),
        .num_lo  (acc_reg[T_W-1:0]),
        .divisor (den_reg),
        .status  (div_st),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Decide hit, saturation, update and hit point offset
    always_comb
    begin
        accept   = (state_reg == ST_IDLE) && ray_valid;
        hit_ok   = !tn_reg[CROSS_W-1] && !un_reg[CROSS_W-1] && (un_reg <= den_reg);
        t_sat    = ({{T_SAT_SH{1'b0}}, tn_reg} >= {den_reg, {T_SAT_SH{1'b0}}});
        upd      = !best_found_reg || (tq_reg < best_t_reg);
        out_free = !res_valid_reg || !res_stall;

        e_sel  = axis_reg ? ey_reg : ex_reg;
        e_neg  = e_sel[DIFF_W-1];
        e_abs  = e_neg ? DIFF_W'(-e_sel) : DIFF_W'(e_sel);
        a_sel  = axis_reg ? ay_reg : ax_reg;
        q_part = {1'b0, div_quot[DIFF_W-1:0]};
        q_up   = q_part + (DIFF_W + 1)'(div_rem != '0);
        h_off  = e_neg ? (DIFF_W + 1)'(-q_up) : q_part;
        h_sum  = {{2{a_sel[COORD_W-1]}}, a_sel} + h_off;
        h_val  = h_sum[COORD_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (ray_valid)
                    state_next = ST_MUL;
            ST_MUL:
                if (mcnt_reg == XPROD_LAST)
                    state_next = ST_NORM;
            ST_NORM:
                state_next = (den_reg == '0) ? ST_FINISH : ST_CHECK;
            ST_CHECK:
                if (!hit_ok)
                    state_next = ST_FINISH;
                else if (t_sat)
                    state_next = ST_TCMP;
                else
                    state_next = ST_DSTART;
            ST_DSTART:
                state_next = ST_DWAIT;
            ST_DWAIT:
                if (div_st.done)
                    state_next = h_phase_reg ? ST_HFIX : ST_TCMP;
            ST_TCMP:
                state_next = upd ? ST_HMUL : ST_FINISH;
            ST_HMUL:
                if (mcnt_reg == HPROD_LAST)
                    state_next = ST_DSTART;
            ST_HFIX:
                state_next = axis_reg ? ST_FINISH : ST_HMUL;
            ST_FINISH:
                if (!last_reg || out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: stall, multiplier operands, divider start, emit
    always_comb
    begin
        ray_stall = (state_reg != ST_IDLE);
        div_start = (state_reg == ST_DSTART);
        emit      = (state_reg == ST_FINISH) && last_reg && out_free;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_MUL:
                case (mcnt_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(dx_reg);
                        mul_b = MUL_W'(ey_reg);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(dy_reg);
                        mul_b = MUL_W'(ex_reg);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(wx_reg);
                        mul_b = MUL_W'(ey_reg);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(wy_reg);
                        mul_b = MUL_W'(ex_reg);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(wx_reg);
                        mul_b = MUL_W'(dy_reg);
                    end
                    3'd5:
                    begin
                        mul_a = MUL_W'(wy_reg);
                        mul_b = MUL_W'(dx_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            ST_HMUL:
                case (mcnt_reg)
                    3'd0:
                    begin
                        mul_a = $signed({1'b0, e_abs});
                        mul_b = $signed({1'b0, un_reg[DIFF_W-1:0]});
                    end
                    3'd1:
                    begin
                        mul_a = $signed({1'b0, e_abs});
                        mul_b = $signed(un_reg[CROSS_W-1:DIFF_W]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control registers and the kept hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mcnt_reg       <= '0;
            axis_reg       <= 1'b0;
            h_phase_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the multiplier issue counter
            if (accept || (state_reg == ST_TCMP) || (state_reg == ST_HFIX))
                mcnt_reg <= '0;
            else if ((state_reg == ST_MUL) || (state_reg == ST_HMUL))
                mcnt_reg <= mcnt_reg + MCNT_W'(1);

            // Track which division is running and which axis
            if (state_reg == ST_CHECK)
                h_phase_reg <= 1'b0;
            else if (state_reg == ST_HMUL)
                h_phase_reg <= 1'b1;

            if (state_reg == ST_TCMP)
                axis_reg <= 1'b0;
            else if (state_reg == ST_HFIX)
                axis_reg <= 1'b1;

            // Commit the new nearest hit once both coordinates are known
            if ((state_reg == ST_HFIX) && axis_reg)
            begin
                best_found_reg <= 1'b1;
                best_x_reg     <= cand_x_reg;
                best_y_reg     <= h_val;
                best_t_reg     <= tq_reg;
            end
            else if (emit)
            begin
                best_found_reg <= 1'b0;
                best_x_reg     <= '0;
                best_y_reg     <= '0;
                best_t_reg     <= '0;
            end

            // Hold the result until taken
            if (emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_reg   <= {ray.seg_end_x[COORD_W-1], ray.seg_end_x}
                      - {ray.seg_start_x[COORD_W-1], ray.seg_start_x};
            ey_reg   <= {ray.seg_end_y[COORD_W-1], ray.seg_end_y}
                      - {ray.seg_start_y[COORD_W-1], ray.seg_start_y};
            wx_reg   <= {ray.seg_start_x[COORD_W-1], ray.seg_start_x}
                      - {ray.ray_origin_x[COORD_W-1], ray.ray_origin_x};
            wy_reg   <= {ray.seg_start_y[COORD_W-1], ray.seg_start_y}
                      - {ray.ray_origin_y[COORD_W-1], ray.ray_origin_y};
            dx_reg   <= ray.ray_dir_x;
            dy_reg   <= ray.ray_dir_y;
            ax_reg   <= ray.seg_start_x;
            ay_reg   <= ray.seg_start_y;
            last_reg <= ray.last_segment;
        end

        // Accumulate the cross products one product per cycle
        if (state_reg == ST_MUL)
        begin
            case (mcnt_reg)
                3'd1: den_reg <= CROSS_W'(mul_p);
                3'd2: den_reg <= den_reg - CROSS_W'(mul_p);
                3'd3: tn_reg  <= CROSS_W'(mul_p);
                3'd4: tn_reg  <= tn_reg - CROSS_W'(mul_p);
                3'd5: un_reg  <= CROSS_W'(mul_p);
                3'd6: un_reg  <= un_reg - CROSS_W'(mul_p);
                default: ;
            endcase
        end

        // Make the denominator positive
        if ((state_reg == ST_NORM) && den_reg[CROSS_W-1])
        begin
            den_reg <= -den_reg;
            tn_reg  <= -tn_reg;
            un_reg  <= -un_reg;
        end

        // Load the ray parameter dividend, or saturate
        if ((state_reg == ST_CHECK) && hit_ok)
        begin
            if (t_sat)
                tq_reg <= '1;
            else
                acc_reg <= NUM_W'($unsigned(tn_reg)) << PARAM_FRAC_BITS;
        end

        if ((state_reg == ST_DWAIT) && div_st.done && !h_phase_reg)
            tq_reg <= div_quot;

        // Build |e| * un from two partial products
        if (state_reg == ST_HMUL)
        begin
            case (mcnt_reg)
                3'd1: acc_reg <= NUM_W'(mul_p);
                3'd2: acc_reg <= acc_reg + (NUM_W'(mul_p) << DIFF_W);
                default: ;
            endcase
        end

        if ((state_reg == ST_HFIX) && !axis_reg)
            cand_x_reg <= h_val;

        // Load the result item
        if (emit)
        begin
            res_reg.hit_valid <= best_found_reg;
            res_reg.hit_x     <= best_x_reg;
            res_reg.hit_y     <= best_y_reg;
            res_reg.hit_param <= best_t_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### src/nrsh_checker.sv
// Port-level checks for nearest_ray_segment_hit, bound to the top level.
// Depends on nrsh_pkg for the item types.
module nrsh_checker
    import nrsh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      ray_valid,
    input logic      ray_stall,
    input logic      res_valid,
    input logic      res_stall,
    input hit_item_t res
);

    // Hold a stalled result item
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // Stall the next item while one is at work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && !ray_stall |=> ray_stall)
        else $error("input taken while an item is still at work");

    // Drive zeros on a no-hit result
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit_valid |->
            res.hit_x == '0 && res.hit_y == '0 && res.hit_param == '0)
        else $error("no-hit result carries non-zero fields");

    // Raise a result only at the end of an item's work
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(ray_stall))
        else $error("result appeared without an item at work");

endmodule

bind nearest_ray_segment_hit nrsh_checker u_nrsh_checker (.*);

### test/nearest_ray_segment_hit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest ray/segment hit finder.
// Depends on nrsh_pkg and the nearest_ray_segment_hit top level, which needs nrsh_mul and nrsh_div.
module nearest_ray_segment_hit_test;
    import nrsh_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 4000;   // quiet cycles before the run is abandoned
    localparam int HOLD_CYCLES  = 800;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;    // covers the slowest item plus the output
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_ITEMS = 280;
    localparam int ITEM_W       = $bits(seg_item_t);

    // Kinds of item that cannot hit
    typedef enum int {
        ODD_PARALLEL,
        ODD_NO_DIR,
        ODD_POINT
    } odd_kind_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      ray_valid = 1'b0;
    seg_item_t ray       = '0;
    logic      res_stall = 1'b0;
    logic      ray_stall;
    logic      res_valid;
    hit_item_t res;

    // Nearest hit kept so far for the open group
    logic                      near_found = 1'b0;
    logic signed [COORD_W-1:0] near_x     = '0;
    logic signed [COORD_W-1:0] near_y     = '0;
    logic [T_W-1:0]            near_t     = '0;

    hit_item_t expected_hits[$];

    int send_idle     = IDLE_PCT;
    int recv_idle     = IDLE_PCT;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int mismatch_cnt  = 0;
    int n_sent        = 0;
    int n_groups      = 0;
    int n_checked     = 0;
    int n_hits        = 0;

    nearest_ray_segment_hit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_stall (ray_stall),
        .ray       (ray),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #CLK_HALF clk = ~clk;

    // Symmetric random integer in [-lim, lim]
    function automatic int sym_rand(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // floor(n / d) for d > 0
    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic seg_item_t mk_seg(input int px, input int py, input int dx, input int dy,
                                         input int ax, input int ay, input int bx, input int by,
                                         input logic last);
        seg_item_t it;
        it.ray_origin_x = COORD_W'(px);
        it.ray_origin_y = COORD_W'(py);
        it.ray_dir_x    = COORD_W'(dx);
        it.ray_dir_y    = COORD_W'(dy);
        it.seg_start_x  = COORD_W'(ax);
        it.seg_start_y  = COORD_W'(ay);
        it.seg_end_x    = COORD_W'(bx);
        it.seg_end_y    = COORD_W'(by);
        it.last_segment = last;
        return it;
    endfunction

    // Fold one accepted item into the kept hit; queue a result at the group end
    function automatic void track_nearest(input seg_item_t it);
        longint          px, py, dx, dy, ax, ay, bx, by;
        longint          ex, ey, wx, wy, den, tn, un;
        longint unsigned tq;
        hit_item_t       r;
        px = $signed(it.ray_origin_x);
        py = $signed(it.ray_origin_y);
        dx = $signed(it.ray_dir_x);
        dy = $signed(it.ray_dir_y);
        ax = $signed(it.seg_start_x);
        ay = $signed(it.seg_start_y);
        bx = $signed(it.seg_end_x);
        by = $signed(it.seg_end_y);
        ex = bx - ax;
        ey = by - ay;
        wx = ax - px;
        wy = ay - py;
        den = dx * ey - dy * ex;
        tn  = wx * ey - wy * ex;
        un  = wx * dy - wy * dx;
        if (den != 0)
        begin
            if (den < 0)
            begin
                den = -den;
                tn  = -tn;
                un  = -un;
            end
            if (tn >= 0 && un >= 0 && un <= den)
            begin
                tq = tn;
                tq = (tq << PARAM_FRAC_BITS) / den;
                if (tq > 64'hFFFF_FFFF)
                    tq = 64'hFFFF_FFFF;
                // Replace only on a strictly nearer hit
                if (!near_found || tq < near_t)
                begin
                    near_found = 1'b1;
                    near_t     = T_W'(tq);
                    near_x     = COORD_W'(ax + floor_quot(ex * un, den));
                    near_y     = COORD_W'(ay + floor_quot(ey * un, den));
                end
            end
        end
        if (it.last_segment)
        begin
            r.hit_valid = near_found;
            r.hit_x     = near_found ? near_x : '0;
            r.hit_y     = near_found ? near_y : '0;
            r.hit_param = near_found ? near_t : '0;
            expected_hits.push_back(r);
            n_groups++;
            near_found = 1'b0;
            near_x     = '0;
            near_y     = '0;
            near_t     = '0;
        end
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_seg(input seg_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            ray_valid <= 1'b0;
            @(posedge clk);
        end
        ray_valid <= 1'b1;
        ray       <= it;
        do
        begin
            @(posedge clk);
        end
        while (ray_stall);
        n_sent++;
        track_nearest(it);
    endtask

    // Segment aimed near a point on the ray, sometimes behind the origin
    function automatic seg_item_t aimed_seg(input int px, input int py, input int dx,
                                            input int dy, input logic last);
        int q4, qx, qy, vx, vy, k;
        q4 = int'($urandom_range(0, 20)) - 4;
        qx = px + (dx * q4) / 4 + sym_rand(2);
        qy = py + (dy * q4) / 4 + sym_rand(2);
        vx = sym_rand(1023);
        vy = sym_rand(1023);
        k  = $urandom_range(1, 3);
        return mk_seg(px, py, dx, dy, qx + vx, qy + vy, qx - vx * k, qy - vy * k, last);
    endfunction

    // Parallel pair, zero direction or zero-length segment
    function automatic seg_item_t odd_seg(input int px, input int py, input int dx,
                                          input int dy, input logic last);
        int        ax, ay, k;
        odd_kind_t kind;
        ax   = sym_rand(16384);
        ay   = sym_rand(16384);
        k    = $urandom_range(1, 2);
        kind = odd_kind_t'($urandom_range(0, 2));
        if ($urandom_range(1))
            k = -k;
        case (kind)
            ODD_PARALLEL: return mk_seg(px, py, dx, dy, ax, ay, ax + dx * k, ay + dy * k, last);
            ODD_NO_DIR:   return mk_seg(px, py, 0, 0, ax, ay, -ax, -ay, last);
            default:      return mk_seg(px, py, dx, dy, ax, ay, ax, ay, last);
        endcase
    endfunction

    // One group of segments against a shared ray, closed by the last segment
    task automatic send_random_group();
        seg_item_t it;
        int        n_segs, px, py, dx, dy, pick;
        n_segs = $urandom_range(1, 6);
        px = sym_rand(16384);
        py = sym_rand(16384);
        dx = sym_rand(2048);
        dy = sym_rand(2048);
        for (int i = 0; i < n_segs; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                it = aimed_seg(px, py, dx, dy, i == n_segs - 1);
            else if (pick < 85)
                it = odd_seg(px, py, dx, dy, i == n_segs - 1);
            else
            begin
                // Noise: every coordinate field at random over its full range
                it = seg_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
                it.last_segment = (i == n_segs - 1);
            end
            send_seg(it);
        end
    endtask

    task automatic test_directed();
        // Plain hit, hit behind the origin, both segment ends, just past an end
        send_seg(mk_seg(0, 0, 4096, 0, 8192, -4096, 8192, 4096, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, -8192, -4096, -8192, 4096, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, 8192, 0, 8192, 4096, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, 8192, -4096, 8192, 0, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, 8192, 1, 8192, 4096, 1'b1));
        // Hit at the origin itself
        send_seg(mk_seg(0, 0, 4096, 0, 0, -4096, 0, 4096, 1'b1));
        // Parallel, collinear, zero direction, zero-length segment on the ray
        send_seg(mk_seg(0, 0, 4096, 0, 0, 4096, 8192, 4096, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, 4096, 0, 8192, 0, 1'b1));
        send_seg(mk_seg(0, 0, 0, 0, 8192, -4096, 8192, 4096, 1'b1));
        send_seg(mk_seg(0, 0, 4096, 0, 8192, 0, 8192, 0, 1'b1));
        // Nearer hit arriving later in the group replaces the kept one
        send_seg(mk_seg(0, 0, 4096, 0, 12288, -4096, 12288, 4096, 1'b0));
        send_seg(mk_seg(0, 0, 4096, 0, 4096, -4096, 4096, 4096, 1'b0));
        send_seg(mk_seg(0, 0, 4096, 0, 8192, -4096, 8192, 4096, 1'b1));
        // Equal quantised t with different points: the earlier hit stays
        send_seg(mk_seg(0, 0, 32767, 0, 8192, -4096, 8192, 4096, 1'b0));
        send_seg(mk_seg(0, 0, 32767, 0, 8191, -9, 8192, 1, 1'b1));
        send_seg(mk_seg(0, 0, 32767, 0, 8191, -9, 8192, 1, 1'b0));
        send_seg(mk_seg(0, 0, 32767, 0, 8192, -4096, 8192, 4096, 1'b1));
        // Field extremes and the largest reachable t
        send_seg(mk_seg(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 1'b1));
        send_seg(mk_seg(-32768, 0, 1, 0, 32767, -32768, 32767, 32767, 1'b1));
        send_seg(mk_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
        send_seg(mk_seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        1'b1));
        // Group with no hit at all: one segment behind the ray, one parallel to it
        send_seg(mk_seg(0, 0, -4096, 0, 8192, -4096, 8192, 4096, 1'b0));
        send_seg(mk_seg(0, 0, -4096, 0, 8192, 4096, 16384, 4096, 1'b1));
    endtask

    task automatic test_random_groups();
        int stop_at;
        stop_at = n_sent + RANDOM_ITEMS;
        while (n_sent < stop_at)
            send_random_group();
    endtask

    task automatic test_full_rate();
        int stop_at;
        send_idle = 0;
        recv_idle = 0;
        stop_at   = n_sent + 60;
        while (n_sent < stop_at)
            send_random_group();
        send_idle = IDLE_PCT;
        recv_idle = IDLE_PCT;
    endtask

    // Hold the output off while short groups keep arriving, so the input stalls
    task automatic test_output_hold();
        int px, py, dx, dy;
        send_idle = 0;
        hold_req++;
        for (int g = 0; g < 12; g++)
        begin
            px = sym_rand(16384);
            py = sym_rand(16384);
            dx = sym_rand(2048);
            dy = sym_rand(2048);
            if (g[0])
                send_seg(aimed_seg(px, py, dx, dy, 1'b0));
            send_seg(aimed_seg(px, py, dx, dy, 1'b1));
        end
        send_idle = IDLE_PCT;
    endtask

    // Compare one accepted result with the oldest expectation
    function automatic void check_hit(input hit_item_t got);
        hit_item_t exp_hit;
        if (expected_hits.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: result with nothing expected: valid=%0b x=%0d y=%0d t=%h",
                         $realtime, got.hit_valid, got.hit_x, got.hit_y, got.hit_param);
            return;
        end
        exp_hit = expected_hits.pop_front();
        n_checked++;
        if (exp_hit.hit_valid)
            n_hits++;
        if (got.hit_valid !== exp_hit.hit_valid || got.hit_x !== exp_hit.hit_x ||
            got.hit_y !== exp_hit.hit_y || got.hit_param !== exp_hit.hit_param)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: result %0d expected valid=%0b x=%0d y=%0d t=%h,",
                         $realtime, n_checked, exp_hit.hit_valid, exp_hit.hit_x,
                         exp_hit.hit_y, exp_hit.hit_param,
                         " got valid=%0b x=%0d y=%0d t=%h",
                         got.hit_valid, got.hit_x, got.hit_y, got.hit_param);
        end
    endfunction

    // Receiver: check accepted results, stall at random or for a long hold-off
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            check_hit(res);
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle);
    end

    // Abandon the run when no item moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((ray_valid && !ray_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_groups();
        test_full_rate();
        test_output_hold();

        // Drain outstanding results, then watch for strays
        ray_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d segment items in %0d ray groups; %0d results checked, %0d hits.",
                 n_sent, n_groups, n_checked, n_hits);
        $display("Included ties, parallel and degenerate cases, full-rate and held-off output.");
        if (mismatch_cnt == 0 && expected_hits.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
src/nrsh_pkg.sv
src/nrsh_mul.sv
src/nrsh_div.sv
src/nearest_ray_segment_hit.sv
src/nrsh_checker.sv
test/nearest_ray_segment_hit_test.sv
